### sv/alc_pkg.sv
// alc_pkg: opcode and status codes plus the per-cell control flags of the
// array list with cursor. No dependencies; imported by alc_cell and the top level.
`default_nettype none

package alc_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIRST  = 2'd1,
    OP_NEXT   = 2'd2,
    OP_REMOVE = 2'd3
  } alc_op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_END   = 3'd3,
    ST_NOCUR = 3'd4
  } alc_status_t;

  typedef struct packed {
    logic ins_ok;
    logic rem_ok;
  } alc_ctrl_t;

endpackage

`default_nettype wire

### sv/alc_cell.sv
// alc_cell: one list entry, loaded on append or shifted down from its upper
// neighbor on remove; drives a read-gated copy for the read bus. Uses alc_pkg.
`default_nettype none

module alc_cell
  import alc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int CW         = 7,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire alc_ctrl_t             ctrl,
  input  wire logic [CW-1:0]         wr_pos,
  input  wire logic [IW-1:0]         cur_pos,
  input  wire logic [IW-1:0]         rd_pos,
  input  wire logic [DATA_WIDTH-1:0] wr_word,
  input  wire logic [DATA_WIDTH-1:0] nbr_word,
  output logic      [DATA_WIDTH-1:0] word,
  output logic      [DATA_WIDTH-1:0] rd_word
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_ok && (wr_pos == CW'(INDEX))) begin
      data_nxt = wr_word;
    end else if (ctrl.rem_ok && (IW'(INDEX) >= cur_pos)) begin
      data_nxt = nbr_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word    = data_r;
  assign rd_word = (rd_pos == IW'(INDEX)) ? data_r : '0;

endmodule

`default_nettype wire

### sv/array_list_with_cursor.sv
// array_list_with_cursor: packed list of data words with an iteration cursor,
// built as a row of alc_cell entries. Uses alc_pkg and alc_cell.
//
// Input channel in_*: in_tuser carries the opcode (insert, first, next,
// remove current), in_tdata the word appended by insert. Result channel out_*:
// one transfer per accepted item; out_tuser carries the status, out_tdata the
// word read or removed and the entry count after the operation.
// For each item the cell row updates every entry in parallel,
// a remove shifting all entries above the cursor down at once, and the read
// word comes from a one-hot gated OR over the cells. The result is held in
// the output register from the cycle after the input transfer, so a new item
// is taken every cycle while the receiver keeps up.
// When out_tready is low the result holds and in_tready drops until the
// result is taken; the next item is taken in that same cycle.
// Reset empties the list and clears the cursor; entry storage is not cleared,
// entries at or above the count are never read.
`default_nettype none

module array_list_with_cursor
  import alc_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int IW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // data_in
  input  wire logic [1:0]       in_tuser,   // opcode
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata,  // data_out, entry_count
  output logic      [2:0]       out_tuser   // status
);

  logic                  in_xfer;
  alc_op_t               op;
  logic [DATA_WIDTH-1:0] in_word;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  cur_vld_r;
  logic                  cur_vld_nxt;
  logic [IW-1:0]         cur_r;
  logic [IW-1:0]         cur_nxt;

  logic                  out_vld_r;
  logic                  out_vld_nxt;
  logic [DATA_WIDTH-1:0] dout_r;
  logic [DATA_WIDTH-1:0] dout_nxt;
  alc_status_t           status_r;
  alc_status_t           status_nxt;
  logic [CW-1:0]         ocount_r;

  alc_ctrl_t             ctrl;
  logic                  rd_en;
  logic [IW-1:0]         rd_pos;
  logic [CW-1:0]         nxt_pos;
  logic [DATA_WIDTH-1:0] rd_data;

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  assign in_tready = !out_vld_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign op        = alc_op_t'(in_tuser);
  assign in_word   = in_tdata[DATA_WIDTH-1:0];
  assign nxt_pos   = cur_vld_r ? (CW'(cur_r) + CW'(1)) : '0;

  always_comb begin
    ctrl        = '0;
    rd_en       = 1'b0;
    rd_pos      = '0;
    count_nxt   = count_r;
    cur_vld_nxt = cur_vld_r;
    cur_nxt     = cur_r;
    status_nxt  = ST_OK;
    case (op)
      OP_INSERT: begin
        if (count_r == CW'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins_ok = in_xfer;
          count_nxt   = count_r + CW'(1);
        end
      end
      OP_FIRST: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en       = 1'b1;
          cur_vld_nxt = 1'b1;
          cur_nxt     = '0;
        end
      end
      OP_NEXT: begin
        if (nxt_pos >= count_r) begin
          status_nxt = ST_END;
        end else begin
          rd_en       = 1'b1;
          rd_pos      = nxt_pos[IW-1:0];
          cur_vld_nxt = 1'b1;
          cur_nxt     = nxt_pos[IW-1:0];
        end
      end
      OP_REMOVE: begin
        if (!cur_vld_r || (CW'(cur_r) >= count_r)) begin
          status_nxt = ST_NOCUR;
        end else begin
          ctrl.rem_ok = in_xfer;
          rd_en       = 1'b1;
          rd_pos      = cur_r;
          count_nxt   = count_r - CW'(1);
          cur_vld_nxt = (cur_r != '0);
          cur_nxt     = cur_r - IW'(1);
        end
      end
      default: begin
        status_nxt = ST_NOCUR;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] nbr;
      if (gi == DEPTH - 1) begin : g_top
        assign nbr = cell_word[gi];
      end else begin : g_mid
        assign nbr = cell_word[gi+1];
      end
      alc_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW),
        .INDEX      (gi)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .wr_pos   (count_r),
        .cur_pos  (cur_r),
        .rd_pos   (rd_pos),
        .wr_word  (in_word),
        .nbr_word (nbr),
        .word     (cell_word[gi]),
        .rd_word  (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  assign dout_nxt    = rd_en ? rd_data : '0;
  assign out_vld_nxt = in_xfer ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cur_vld_r <= 1'b0;
      cur_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_xfer) begin
        count_r   <= count_nxt;
        cur_vld_r <= cur_vld_nxt;
        cur_r     <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dout_r   <= dout_nxt;
      status_r <= status_nxt;
      ocount_r <= count_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({ocount_r, dout_r});
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

### bench/tb_array_list_with_cursor.sv
// tb_array_list_with_cursor: self-checking bench for the array list with cursor;
// a directed table, then random insert/walk/drain runs; results checked against
// typed rows or an in-bench list model. Uses alc_pkg, array_list_with_cursor.
`default_nettype none

module tb_array_list_with_cursor
  import alc_pkg::*;
();

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 525;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    logic [31:0] word;
    alc_status_t status;
    logic [6:0]  count;
  } list_result_t;

  typedef struct packed {
    alc_op_t      op;
    logic [31:0]  word;
    logic         typed;
    list_result_t result;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, ST_NOCUR, 7'd0}},
    '{OP_FIRST,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 7'd0}},
    '{OP_NEXT,   32'hffff_ffff, 1'b1, '{32'h0, ST_END,   7'd0}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0, ST_OK,    7'd1}},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, '{32'h0, ST_OK,    7'd2}},
    '{OP_INSERT, 32'ha5a5_a5a5, 1'b1, '{32'h0, ST_OK,    7'd3}},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b1, '{32'h0, ST_OK,    7'd4}},
    '{OP_NEXT,   32'h1234_5678, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_NEXT,   32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'hdead_beef, 1'b1, '{32'h0, ST_NOCUR, 7'd2}},
    '{OP_NEXT,   32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_NEXT,   32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_NEXT,   32'h0000_0000, 1'b1, '{32'h0, ST_END,   7'd2}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_FIRST,  32'hffff_ffff, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_INSERT, 32'h8000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_INSERT, 32'h0000_0001, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_FIRST,  32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_NEXT,   32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, ST_OK,    7'd0}}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // data_in
  logic [1:0]  in_tuser   = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // data_out, entry_count
  logic [2:0]  out_tuser;         // status

  array_list_with_cursor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // list model state
  logic [31:0] list_mem [LIST_DEPTH];
  int          model_count = 0;
  bit          cur_valid   = 1'b0;
  int          cur_pos     = 0;

  list_result_t pending_results [$];
  int fail_cnt    = 0;
  int sent_cnt    = 0;
  int checked_cnt = 0;
  int peak_len    = 0;
  int status_seen [5] = '{0, 0, 0, 0, 0};
  int burst_left  = 0;
  int cycle_cnt   = 0;
  int rdy_mode    = 0;
  int rdy_left    = 0;
  int rdy_phase   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern: always ready, random, periodic or mostly stalled
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(16, 80);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    rdy_phase <= rdy_phase + 1;
    case (rdy_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ((rdy_phase % 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic apply_list_op(input alc_op_t op, input logic [31:0] word,
                               output list_result_t res);
    int nxt;
    res.word   = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (model_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_mem[model_count] = word;
          model_count++;
        end
      end
      OP_FIRST: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          cur_valid = 1'b1;
          cur_pos   = 0;
          res.word  = list_mem[0];
        end
      end
      OP_NEXT: begin
        nxt = cur_valid ? cur_pos + 1 : 0;
        if (nxt >= model_count) begin
          res.status = ST_END;
        end else begin
          cur_valid = 1'b1;
          cur_pos   = nxt;
          res.word  = list_mem[nxt];
        end
      end
      default: begin
        if (!cur_valid || cur_pos >= model_count) begin
          res.status = ST_NOCUR;
        end else begin
          res.word = list_mem[cur_pos];
          for (int i = cur_pos; i + 1 < model_count; i++) list_mem[i] = list_mem[i + 1];
          model_count--;
          if (cur_pos == 0) cur_valid = 1'b0;
          else cur_pos--;
        end
      end
    endcase
    res.count = model_count[6:0];
    if (model_count > peak_len) peak_len = model_count;
  endtask

  task automatic send_item(input alc_op_t op, input logic [31:0] word,
                           input logic typed, input list_result_t typed_res);
    int gap;
    list_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    apply_list_op(op, word, res);
    pending_results.push_back(typed ? typed_res : res);
    burst_left--;
    sent_cnt++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input alc_op_t op);
    send_item(op, rand_word(), 1'b0, '0);
  endtask

  always @(posedge clk) begin : result_check
    list_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: data_out %h status %0d count %0d",
               out_tdata[31:0], out_tuser, out_tdata[38:32]);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[31:0] !== exp_res.word) begin
          $error("data_out expected %h actual %h", exp_res.word, out_tdata[31:0]);
          fail_cnt++;
        end
        if (out_tuser !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, out_tuser);
          fail_cnt++;
        end
        if (out_tdata[38:32] !== exp_res.count) begin
          $error("entry_count expected %0d actual %0d", exp_res.count, out_tdata[38:32]);
          fail_cnt++;
        end
        checked_cnt++;
        if (exp_res.status <= ST_NOCUR) status_seen[exp_res.status]++;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(DIRECTED[r].op, DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].result);
    end

    while (sent_cnt < NUM_DIRECTED + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          // fill to capacity and push a few past it
          n = LIST_DEPTH - model_count + $urandom_range(1, 3);
          repeat (n) send_op(OP_INSERT);
        end
        1, 2: begin
          repeat ($urandom_range(1, 8)) send_op(OP_INSERT);
        end
        3, 4, 5: begin
          send_op(OP_FIRST);
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 3) == 0) send_op(OP_REMOVE);
            else send_op(OP_NEXT);
          end
        end
        6, 7: begin
          // drain from the head, cut short at random
          send_op(OP_FIRST);
          n = (model_count == 0) ? 1 : $urandom_range(1, model_count + 1);
          repeat (n) begin
            send_op(OP_REMOVE);
            send_op(OP_NEXT);
          end
        end
        default: begin
          repeat ($urandom_range(1, 6)) send_op(alc_op_t'($urandom_range(0, 3)));
        end
      endcase
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d transfers, checked %0d results, peak list length %0d",
             sent_cnt, checked_cnt, peak_len);
    $display("status mix: ok %0d full %0d empty %0d end %0d no-cursor %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
